[design/tmtw_pkg.sv]
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared constants and controller/datapath interface types for the
// text-mode terminal writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmtw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);

  localparam int unsigned CELL_W  = 16;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned IN_ADDR_W = 11;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic accept_put;
    logic accept_read;
    logic clear_wr;
    logic copy_rd;
    logic drain;
    logic fill_wr;
    logic emit;
    logic emit_read;
    logic emit_scrolled;
  } tmtw_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic cnt_last;
  } tmtw_status_t;

endpackage

[design/tmtw_ram.sv]
// ----------------------------------------------------------------------------
// tmtw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/tmtw_datapath.sv]
// ----------------------------------------------------------------------------
// tmtw_datapath
// Screen store, cursor, sweep counter, scroll copy pipeline and result
// registers of the text-mode terminal writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmtw_pkg::tmtw_cmd_t               cmd_i,
  output tmtw_pkg::tmtw_status_t            status_o,
  input  logic [tmtw_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tmtw_pkg::IN_ADDR_W-1:0]    cell_address_i,
  input  logic                              text_color_we_i,
  input  logic [tmtw_pkg::COLOR_W-1:0]      text_color_i,
  output logic                              done_o,
  output logic [tmtw_pkg::CELL_W-1:0]       cell_entry_o,
  output logic [tmtw_pkg::POS_W-1:0]        cursor_position_o,
  output logic                              scrolled_o
);

  localparam logic [tmtw_pkg::COL_W-1:0]  LastCol  = tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS - 1);
  localparam logic [tmtw_pkg::ROW_W-1:0]  LastRow  = tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1);
  localparam logic [tmtw_pkg::ADDR_W-1:0] RowStep  = tmtw_pkg::ADDR_W'(tmtw_pkg::COLUMNS);
  localparam logic [tmtw_pkg::ADDR_W-1:0] LastCell =
    tmtw_pkg::ADDR_W'(tmtw_pkg::CELL_COUNT - 1);
  localparam logic [tmtw_pkg::ADDR_W-1:0] LastRowBase =
    tmtw_pkg::ADDR_W'(tmtw_pkg::CELL_COUNT - tmtw_pkg::COLUMNS);

  logic [tmtw_pkg::COLOR_W-1:0] color_q;
  logic [tmtw_pkg::COL_W-1:0]   col_q;
  logic [tmtw_pkg::ROW_W-1:0]   row_q;
  logic [tmtw_pkg::ADDR_W-1:0]  base_q;
  logic [tmtw_pkg::ADDR_W-1:0]  cnt_q;
  logic                         cp_v_q;
  logic [tmtw_pkg::ADDR_W-1:0]  cp_addr_q;
  logic                         oor_q;
  logic                         done_q;
  logic [tmtw_pkg::CELL_W-1:0]  entry_q;
  logic [tmtw_pkg::POS_W-1:0]   pos_q;
  logic                         scrolled_q;

  logic                         is_nl;
  logic                         row_end;
  logic                         ram_we;
  logic [tmtw_pkg::ADDR_W-1:0]  ram_waddr;
  logic [tmtw_pkg::CELL_W-1:0]  ram_wdata;
  logic [tmtw_pkg::ADDR_W-1:0]  ram_raddr;
  logic [tmtw_pkg::CELL_W-1:0]  ram_rdata;
  logic [tmtw_pkg::ADDR_W-1:0]  cursor_lin;

  assign is_nl      = (char_code_i == tmtw_pkg::NEWLINE_CODE);
  assign row_end    = is_nl || (col_q == LastCol);
  assign cursor_lin = base_q + tmtw_pkg::ADDR_W'(col_q);

  assign status_o.need_scroll = row_end && (row_q == LastRow);
  assign status_o.cnt_last    = (cnt_q == LastCell);

  // write port: pending copy write first, then sweep or put
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    if (cp_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = cp_addr_q;
      ram_wdata = ram_rdata;
    end else if (cmd_i.clear_wr) begin
      ram_we    = 1'b1;
    end else if (cmd_i.fill_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {color_q, tmtw_pkg::SPACE_CODE};
    end else if (cmd_i.accept_put && !is_nl) begin
      ram_we    = 1'b1;
      ram_waddr = cursor_lin;
      ram_wdata = {color_q, char_code_i};
    end
  end

  assign ram_raddr = cmd_i.copy_rd ? cnt_q : tmtw_pkg::ADDR_W'(cell_address_i);

  tmtw_ram #(
    .WIDTH(tmtw_pkg::CELL_W),
    .DEPTH(tmtw_pkg::CELL_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q    <= tmtw_pkg::RESET_COLOR;
      col_q      <= '0;
      row_q      <= '0;
      base_q     <= '0;
      cnt_q      <= '0;
      cp_v_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (text_color_we_i) begin
        color_q <= text_color_i;
      end
      if (cmd_i.accept_put) begin
        if (row_end) begin
          col_q <= '0;
          if (row_q != LastRow) begin
            row_q  <= row_q + 1'b1;
            base_q <= base_q + RowStep;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (cmd_i.accept_put && status_o.need_scroll) begin
        cnt_q <= RowStep;
      end else if (cmd_i.drain) begin
        cnt_q <= LastRowBase;
      end else if (cmd_i.clear_wr || cmd_i.copy_rd || cmd_i.fill_wr) begin
        cnt_q <= cnt_q + 1'b1;
      end
      cp_v_q <= cmd_i.copy_rd;
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cnt_q - RowStep;
    if (cmd_i.accept_read) begin
      oor_q <= (32'(cell_address_i) >= tmtw_pkg::CELL_COUNT);
    end
    if (cmd_i.emit) begin
      entry_q    <= (cmd_i.emit_read && !oor_q) ? ram_rdata : '0;
      pos_q      <= tmtw_pkg::POS_W'(cursor_lin);
      scrolled_q <= cmd_i.emit_scrolled;
    end
  end

  assign done_o            = done_q;
  assign cell_entry_o      = entry_q;
  assign cursor_position_o = pos_q;
  assign scrolled_o        = scrolled_q;

endmodule

[design/tmtw_controller.sv]
// ----------------------------------------------------------------------------
// tmtw_controller
// Sequencer for clearing, puts, reads and the scroll copy and fill sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_controller (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   kind_i,
  output logic                   busy_o,
  output tmtw_pkg::tmtw_cmd_t    cmd_o,
  input  tmtw_pkg::tmtw_status_t status_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FINISH,
    ST_COPY,
    ST_DRAIN,
    ST_FILL
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == tmtw_pkg::KIND_READ) begin
            cmd_o.accept_read = 1'b1;
            state_d           = ST_READ;
          end else begin
            cmd_o.accept_put = 1'b1;
            state_d          = status_i.need_scroll ? ST_COPY : ST_FINISH;
          end
        end
      end
      ST_READ: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_read = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_FINISH: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.emit          = 1'b1;
          cmd_o.emit_scrolled = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[design/text_mode_terminal_writer_core.sv]
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core
// Text-mode character terminal: a screen store of attribute/character cells
// with a cursor, newline handling, row wrap and scroll-up.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 2000-cell screen store to zero, one cell a
// cycle, and holds busy_o high until the sweep ends. An item is taken when
// start_i is high and busy_o low; its one result appears on done_o and the
// result ports for a single cycle and must be captured then. A read, or a put
// that does not scroll, passes through ST_READ or ST_FINISH and shows its
// result from the done register; the next item can be taken in the cycle
// its result appears. A put that moves past the last row copies every row
// up through the screen RAM, one cell a cycle, then fills the last row with
// spaces; its result follows the fill. The user must write text_color only
// while busy_o is low and no result is pending; the block does not enforce it.
`timescale 1ns / 1ps

module text_mode_terminal_writer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               kind_i,
  input  logic [tmtw_pkg::CHAR_W-1:0]        char_code_i,
  input  logic [tmtw_pkg::IN_ADDR_W-1:0]     cell_address_i,
  input  logic                               text_color_we_i,
  input  logic [tmtw_pkg::COLOR_W-1:0]       text_color_i,
  output logic                               done_o,
  output logic [tmtw_pkg::CELL_W-1:0]        cell_entry_o,
  output logic [tmtw_pkg::POS_W-1:0]         cursor_position_o,
  output logic                               scrolled_o
);

  tmtw_pkg::tmtw_cmd_t    cmd;
  tmtw_pkg::tmtw_status_t status;

  tmtw_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .status_i(status)
  );

  tmtw_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .char_code_i      (char_code_i),
    .cell_address_i   (cell_address_i),
    .text_color_we_i  (text_color_we_i),
    .text_color_i     (text_color_i),
    .done_o           (done_o),
    .cell_entry_o     (cell_entry_o),
    .cursor_position_o(cursor_position_o),
    .scrolled_o       (scrolled_o)
  );

endmodule

[design/tmtw_checker.sv]
// ----------------------------------------------------------------------------
// tmtw_checker
// Port-level checks for the text-mode terminal writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic [tmtw_pkg::CELL_W-1:0]    cell_entry_o,
  input logic [tmtw_pkg::POS_W-1:0]     cursor_position_o,
  input logic                           scrolled_o
);

  localparam logic [tmtw_pkg::POS_W-1:0] LastRowPos =
    tmtw_pkg::POS_W'((tmtw_pkg::ROWS - 1) * tmtw_pkg::COLUMNS);

  // an accepted transfer makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("no busy after accepted transfer");

  // one result per transfer, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // a scroll leaves the cursor at the start of the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cursor_position_o == LastRowPos))
    else $error("scroll with cursor off last row start");

  // a scrolling put returns no cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cell_entry_o == '0))
    else $error("cell data on a scrolling put");

endmodule

bind text_mode_terminal_writer_core tmtw_checker u_tmtw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .cell_entry_o     (cell_entry_o),
  .cursor_position_o(cursor_position_o),
  .scrolled_o       (scrolled_o)
);
